// ===== sv/tskwm_pkg.sv =====
// ----------------------------------------------------------------------------
// tskwm_pkg: shared constants for the timestamp k-way merge
// Field widths of the input and result words and parameter defaults.
// ----------------------------------------------------------------------------
package tskwm_pkg;

  // Fixed field widths of the words on the two channels.
  localparam int unsigned SRC_W  = 4;
  localparam int unsigned DATE_W = 64;
  localparam int unsigned PAY_W  = 32;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned CFG_W  = 5;

  // Defaults for the top-level parameters.
  localparam int unsigned SOURCES_DEF       = 16;
  localparam int unsigned PAYLOAD_BITS_DEF  = 32;
  localparam int unsigned POSITION_BITS_DEF = 32;

endpackage

// ===== sv/tskwm_in_if.sv =====
// ----------------------------------------------------------------------------
// tskwm_in_if: event input channel
// Valid/ready channel that carries one source event per word.
// ----------------------------------------------------------------------------
interface tskwm_in_if;

  logic                             valid;
  logic                             ready;
  logic [tskwm_pkg::SRC_W-1:0]      source_id;
  logic [tskwm_pkg::DATE_W-1:0]     event_date;
  logic [tskwm_pkg::PAY_W-1:0]      event_payload;
  logic                             last_of_source;

  modport source (
    output valid, source_id, event_date, event_payload, last_of_source,
    input  ready
  );

  modport sink (
    input  valid, source_id, event_date, event_payload, last_of_source,
    output ready
  );

endinterface

// ===== sv/tskwm_out_if.sv =====
// ----------------------------------------------------------------------------
// tskwm_out_if: merged event output channel
// Valid/ready channel that carries one emitted event per word.
// ----------------------------------------------------------------------------
interface tskwm_out_if;

  logic                             valid;
  logic                             ready;
  logic [tskwm_pkg::SRC_W-1:0]      out_source;
  logic [tskwm_pkg::DATE_W-1:0]     out_date;
  logic [tskwm_pkg::PAY_W-1:0]      out_payload;
  logic [tskwm_pkg::POS_W-1:0]      out_position;
  logic                             refill_wanted;
  logic                             all_done;

  modport source (
    output valid, out_source, out_date, out_payload, out_position,
           refill_wanted, all_done,
    input  ready
  );

  modport sink (
    input  valid, out_source, out_date, out_payload, out_position,
           refill_wanted, all_done,
    output ready
  );

endinterface

// ===== sv/timestamp_k_way_merge_top.sv =====
// ----------------------------------------------------------------------------
// timestamp_k_way_merge_top: date-ordered merge of sorted event streams
// Holds one pending head per source and emits the earliest head once every
// open source has one, with ties going to the lower source index.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake          Word
//  in_i      in   valid / ready      source_id, event_date, event_payload,
//                                    last_of_source
//  out_o     out  valid / ready      out_source, out_date, out_payload,
//                                    out_position, refill_wanted, all_done
//  cfg       in   cfg_we_i (no wait) cfg_wdata_i = active_sources
//
//  An input word that causes no emission passes through accept and check.
//  A word that causes an emission also passes a scan, in which one date
//  comparator walks the head memory one entry per cycle, then a drain step
//  for the registered read of that memory, a count-read step and the emit step.
//  Reset clears the valid bits and counters at once; there is no clearing
//  pass. A result waits in the output register while the next word is taken;
//  a new emission waits only until that register has been drained.
//
module timestamp_k_way_merge_top #(
  parameter int unsigned SOURCES       = tskwm_pkg::SOURCES_DEF,
  parameter int unsigned PAYLOAD_BITS  = tskwm_pkg::PAYLOAD_BITS_DEF,
  parameter int unsigned POSITION_BITS = tskwm_pkg::POSITION_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tskwm_pkg::CFG_W-1:0] cfg_wdata_i,
  tskwm_in_if.sink                    in_i,
  tskwm_out_if.source                 out_o
);

  // Index width of the per-source stores and width of the source counters.
  localparam int unsigned IDX_W = $clog2(SOURCES);
  localparam int unsigned CNT_W = $clog2(SOURCES + 1);
  // Stored payload width: the port carries at most PAY_W bits.
  localparam int unsigned PL_W  = (PAYLOAD_BITS < tskwm_pkg::PAY_W) ?
                                  PAYLOAD_BITS : tskwm_pkg::PAY_W;
  localparam int unsigned HEAD_W = tskwm_pkg::DATE_W + PL_W + 1;

  // One-hot sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_CNT   = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

  state_e                       state_q, state_d;
  logic [SOURCES-1:0]           head_valid_q, head_valid_d;
  logic [SOURCES-1:0]           cnt_valid_q, cnt_valid_d;
  logic [CNT_W-1:0]             open_q, open_d;
  logic [CNT_W-1:0]             pending_q, pending_d;
  logic [IDX_W-1:0]             idx_q, idx_d;
  logic [IDX_W-1:0]             rd_idx_q, rd_idx_d;
  logic                         rd_pend_q, rd_pend_d;
  logic                         found_q, found_d;
  logic [IDX_W-1:0]             best_q, best_d;
  logic [tskwm_pkg::DATE_W-1:0] best_date_q, best_date_d;
  logic [PL_W-1:0]              best_pay_q, best_pay_d;
  logic                         best_last_q, best_last_d;
  logic                         out_valid_q, out_valid_d;

  // Output payload registers, loaded only when a result is emitted.
  logic [tskwm_pkg::SRC_W-1:0]  o_src_q;
  logic [tskwm_pkg::DATE_W-1:0] o_date_q;
  logic [tskwm_pkg::PAY_W-1:0]  o_pay_q;
  logic [tskwm_pkg::POS_W-1:0]  o_pos_q;
  logic                         o_refill_q;
  logic                         o_done_q;

  // Head memory: {last, payload, date} per source.
  logic                         head_we;
  logic [IDX_W-1:0]             src_idx;
  logic [HEAD_W-1:0]            head_wdata;
  logic [HEAD_W-1:0]            head_rdata;
  logic [tskwm_pkg::DATE_W-1:0] rd_date;
  logic [PL_W-1:0]              rd_pay;
  logic                         rd_last;

  // Position counter memory; an entry whose valid bit is clear reads as zero.
  logic                         cnt_we;
  logic [POSITION_BITS-1:0]     cnt_rdata;
  logic [POSITION_BITS-1:0]     cnt_cur;
  logic [POSITION_BITS-1:0]     cnt_next;

  logic                         in_fire;
  logic                         src_in_range;
  logic                         take_head;
  logic                         emit;
  logic [CNT_W-1:0]             open_after;
  logic [CNT_W-1:0]             cfg_open;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // A source index past the last source is dropped.
  assign src_in_range = (32'(in_i.source_id) < SOURCES);
  assign src_idx      = IDX_W'(in_i.source_id);
  assign head_we      = in_fire && (open_q != '0) && src_in_range &&
                        !head_valid_q[src_idx];
  assign head_wdata   = {in_i.last_of_source, in_i.event_payload[PL_W-1:0],
                         in_i.event_date};

  tskwm_ram #(
    .WIDTH (HEAD_W),
    .DEPTH (SOURCES)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (src_idx),
    .wdata_i (head_wdata),
    .raddr_i (idx_q),
    .rdata_o (head_rdata)
  );

  assign rd_date = head_rdata[tskwm_pkg::DATE_W-1:0];
  assign rd_pay  = head_rdata[tskwm_pkg::DATE_W +: PL_W];
  assign rd_last = head_rdata[HEAD_W-1];

  // The shared comparator: strict less keeps the lower index on equal dates.
  assign take_head = rd_pend_q && head_valid_q[rd_idx_q] &&
                     (!found_q || (rd_date < best_date_q));

  assign emit     = (state_q == ST_EMIT) && !out_valid_q;
  assign cnt_cur  = cnt_valid_q[best_q] ? cnt_rdata : '0;
  assign cnt_next = cnt_cur + 1'b1;
  assign cnt_we   = emit && !best_last_q;

  tskwm_ram #(
    .WIDTH (POSITION_BITS),
    .DEPTH (SOURCES)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (best_q),
    .wdata_i (cnt_next),
    .raddr_i (best_q),
    .rdata_o (cnt_rdata)
  );

  assign open_after = open_q - CNT_W'(best_last_q);
  assign cfg_open   = (32'(cfg_wdata_i) > SOURCES) ? CNT_W'(SOURCES) :
                                                     CNT_W'(cfg_wdata_i);

  always_comb begin
    state_d      = state_q;
    head_valid_d = head_valid_q;
    cnt_valid_d  = cnt_valid_q;
    open_d       = open_q;
    pending_d    = pending_q;
    idx_d        = idx_q;
    rd_idx_d     = rd_idx_q;
    rd_pend_d    = 1'b0;
    found_d      = found_q;
    best_d       = best_q;
    best_date_d  = best_date_q;
    best_pay_d   = best_pay_q;
    best_last_d  = best_last_q;
    out_valid_d  = out_valid_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (take_head) begin
      found_d     = 1'b1;
      best_d      = rd_idx_q;
      best_date_d = rd_date;
      best_pay_d  = rd_pay;
      best_last_d = rd_last;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (head_we) begin
            head_valid_d[src_idx] = 1'b1;
            pending_d             = pending_q + 1'b1;
          end
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // Emit once the pending heads cover every open source.
        if ((open_q == '0) || (pending_q < open_q)) begin
          state_d = ST_IDLE;
        end else begin
          found_d = 1'b0;
          idx_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Read one entry per cycle; its data is compared once the registered read returns it.
        rd_idx_d  = idx_q;
        rd_pend_d = 1'b1;
        if (idx_q == IDX_W'(SOURCES - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_CNT;
      end
      ST_CNT: begin
        state_d = found_q ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (emit) begin
          out_valid_d          = 1'b1;
          head_valid_d[best_q] = 1'b0;
          pending_d            = pending_q - 1'b1;
          if (best_last_q) begin
            cnt_valid_d[best_q] = 1'b0;
            open_d              = open_after;
          end else begin
            cnt_valid_d[best_q] = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      open_d = cfg_open;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_valid_q <= '0;
      cnt_valid_q  <= '0;
      open_q       <= '0;
      pending_q    <= '0;
      idx_q        <= '0;
      rd_idx_q     <= '0;
      rd_pend_q    <= 1'b0;
      found_q      <= 1'b0;
      best_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_valid_q <= head_valid_d;
      cnt_valid_q  <= cnt_valid_d;
      open_q       <= open_d;
      pending_q    <= pending_d;
      idx_q        <= idx_d;
      rd_idx_q     <= rd_idx_d;
      rd_pend_q    <= rd_pend_d;
      found_q      <= found_d;
      best_q       <= best_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    best_date_q <= best_date_d;
    best_pay_q  <= best_pay_d;
    best_last_q <= best_last_d;
    if (emit) begin
      o_src_q    <= tskwm_pkg::SRC_W'(best_q);
      o_date_q   <= best_date_q;
      o_pay_q    <= tskwm_pkg::PAY_W'(best_pay_q);
      o_pos_q    <= tskwm_pkg::POS_W'(cnt_cur);
      o_refill_q <= !best_last_q;
      o_done_q   <= (open_after == '0);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_source    = o_src_q;
  assign out_o.out_date      = o_date_q;
  assign out_o.out_payload   = o_pay_q;
  assign out_o.out_position  = o_pos_q;
  assign out_o.refill_wanted = o_refill_q;
  assign out_o.all_done      = o_done_q;

  // The pending counter always equals the number of set head valid bits.
  a_pending_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pending_q) == $countones(head_valid_q))
    else $error("pending count out of step with head valid bits");

  // An emission always removes a head that was pending.
  a_emit_valid_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> head_valid_q[best_q])
    else $error("emission of a head that is not pending");

  // A new result appears only right after the emit state.
  a_result_from_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_EMIT)
    else $error("result raised outside the emit state");

  // A word is taken only while no scan is in progress.
  a_accept_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_CHECK) && !rd_pend_q)
    else $error("input accepted during a scan");

endmodule

// ===== sv/tskwm_ram.sv =====
// ----------------------------------------------------------------------------
// tskwm_ram: generic single-write, single-read memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tskwm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
